/* hdl/assert_macros.svh */
// assertion macros used by the reverb sequencer
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off during reset
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* hdl/prt_pkg.sv */
// types, constants and arithmetic helpers of the plate reverb tank
// no dependencies
`timescale 1ns / 1ps
package prt_pkg;

  localparam int DIFF_A_LEN = 142;
  localparam int DIFF_B_LEN = 107;
  localparam int NUM_LINES = 8;

  localparam logic [14:0] K_BW      = 15'd32604;
  localparam logic [14:0] K_BW_REST = 15'd164;
  localparam logic [14:0] K_DIFF12  = 15'd24576;
  localparam logic [14:0] K_DIFF34  = 15'd20480;
  localparam logic [14:0] K_DECAY1  = 15'd16384;
  localparam logic [14:0] K_DECAY2  = 15'd13107;
  localparam logic [14:0] K_HALF    = 15'd16384;
  localparam logic [14:0] K_QUARTER = 15'd8192;
  localparam logic [14:0] K_THREEQ  = 15'd24576;
  localparam logic signed [15:0] WET_LIMIT = 16'sd16384;

  localparam logic [14:0] GAIN_ONE_RST   = 15'd8192;
  localparam logic [14:0] GAIN_TWO_RST   = 15'd16384;
  localparam logic [14:0] GAIN_THREE_RST = 15'd16384;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_GAIN1 = 2'd1,
    REG_GAIN2 = 2'd2,
    REG_GAIN3 = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    MODE_BYPASS = 2'd0,
    MODE_LIGHT  = 2'd1,
    MODE_HALF   = 2'd2,
    MODE_WET    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    LN_DA = 3'd0,
    LN_DB = 3'd1,
    LN_DC = 3'd2,
    LN_DD = 3'd3,
    LN_AA = 3'd4,
    LN_AB = 3'd5,
    LN_TA = 3'd6,
    LN_TB = 3'd7
  } line_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_BW1,
    OP_BW2,
    OP_AP1,
    OP_AP2,
    OP_ADDFB,
    OP_TAP1,
    OP_TAP2,
    OP_DELAY,
    OP_DMP1,
    OP_DMP2,
    OP_GAIN,
    OP_GAINFB,
    OP_MIX1,
    OP_MIX2,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BW1,
    ST_BW2,
    ST_DA1,
    ST_DA2,
    ST_DB1,
    ST_DB2,
    ST_DC1,
    ST_DC2,
    ST_DD1,
    ST_DD2,
    ST_FB,
    ST_AA1,
    ST_AA2,
    ST_TA,
    ST_DMP1,
    ST_DMP2,
    ST_G1,
    ST_AB1,
    ST_AB2,
    ST_TB,
    ST_G2,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t         op;
    line_t       line;
    logic [14:0] coef;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic bypass;
    logic out_free;
  } sts_t;

  // q1.15 product truncated toward zero
  function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
                                              input logic [14:0] c);
    logic signed [31:0] p;
    logic signed [31:0] r;
    p = 32'(a) * 32'(signed'({1'b0, c}));
    if (p < 0) begin
      r = -((-p) >>> 15);
    end else begin
      r = p >>> 15;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [17:0] s;
    s = 18'(a) + 18'(b);
    return sat16(s);
  endfunction

  function automatic logic signed [15:0] sub_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [17:0] s;
    s = 18'(a) - 18'(b);
    return sat16(s);
  endfunction

endpackage

/* hdl/plate_reverb_tank.sv */
// plate reverb tank: sample in, sample out, with four control registers
// depends on prt_pkg, prt_ctrl and prt_datapath
//
// usage:
//   sample_in with in_valid/in_ready, sample_out with out_valid/out_ready.
//   registers on the apb-style port: mix_mode at 0x0, decay_gain_one at 0x4,
//   decay_gain_two at 0x8, decay_gain_three at 0xc; write only while idle.
//   after reset every delay line is swept to zero, one entry per cycle, until
//   the longest line (4453 entries by default) is clear; in_ready stays low
//   until the sweep is done. register writes are taken at any time.
//   in bypass mode an accepted word goes straight to the output step; else
//   the sequencer walks it through the chain of allpass, lowpass and gain
//   steps, one datapath step a cycle up to the output step, which can stall.
//   a finished word waits in the output register; while the receiver stalls
//   the next word can be accepted, and the sequencer holds at its last step
//   until the output register frees up.
`timescale 1ns / 1ps
module plate_reverb_tank #(
  parameter int DIFFUSER_C_LEN      = 379,
  parameter int DIFFUSER_D_LEN      = 277,
  parameter int DECAY_ALLPASS_A_LEN = 672,
  parameter int DECAY_ALLPASS_B_LEN = 1800,
  parameter int TANK_DELAY_A_LEN    = 4453,
  parameter int TANK_DELAY_B_LEN    = 3720
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out
);
  import prt_pkg::*;

  logic [1:0]  mix_mode;
  logic [14:0] decay_gain_one, decay_gain_two, decay_gain_three;
  cmd_t        cmd;
  sts_t        sts;
  reg_t        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode         <= MODE_BYPASS;
      decay_gain_one   <= GAIN_ONE_RST;
      decay_gain_two   <= GAIN_TWO_RST;
      decay_gain_three <= GAIN_THREE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_MODE:  mix_mode         <= pwdata[1:0];
        REG_GAIN1: decay_gain_one   <= pwdata[14:0];
        REG_GAIN2: decay_gain_two   <= pwdata[14:0];
        default:   decay_gain_three <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:  prdata = {30'd0, mix_mode};
      REG_GAIN1: prdata = {17'd0, decay_gain_one};
      REG_GAIN2: prdata = {17'd0, decay_gain_two};
      default:   prdata = {17'd0, decay_gain_three};
    endcase
  end

  prt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  prt_datapath #(
    .DIFFUSER_C_LEN     (DIFFUSER_C_LEN),
    .DIFFUSER_D_LEN     (DIFFUSER_D_LEN),
    .DECAY_ALLPASS_A_LEN(DECAY_ALLPASS_A_LEN),
    .DECAY_ALLPASS_B_LEN(DECAY_ALLPASS_B_LEN),
    .TANK_DELAY_A_LEN   (TANK_DELAY_A_LEN),
    .TANK_DELAY_B_LEN   (TANK_DELAY_B_LEN)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mix_mode        (mix_mode),
    .decay_gain_one  (decay_gain_one),
    .decay_gain_two  (decay_gain_two),
    .decay_gain_three(decay_gain_three),
    .sample_in       (sample_in),
    .sample_out      (sample_out),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );
endmodule

/* hdl/prt_line.sv */
// one delay line: memory, write position and clearing sweep after reset
// depends on nothing
`timescale 1ns / 1ps
module prt_line #(
  parameter int DEPTH = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic               wr_en,
  input  logic               adv,
  input  logic signed [15:0] wdata,
  output logic signed [15:0] rdata,
  output logic               busy
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic signed [15:0] mem [DEPTH];
  logic [AW-1:0] pos;
  logic [AW-1:0] clr_idx;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      clr_idx  <= '0;
      clearing <= 1'b1;
    end else begin
      if (clearing) begin
        if (clr_idx == LAST) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
      if (adv) begin
        pos <= (pos == LAST) ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[pos] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[pos];
    end
  end

  assign busy = clearing;
endmodule

/* hdl/prt_datapath.sv */
// reverb datapath: working registers, shared arithmetic and the eight delay lines
// depends on prt_pkg and prt_line
`timescale 1ns / 1ps
module prt_datapath #(
  parameter int DIFFUSER_C_LEN      = 379,
  parameter int DIFFUSER_D_LEN      = 277,
  parameter int DECAY_ALLPASS_A_LEN = 672,
  parameter int DECAY_ALLPASS_B_LEN = 1800,
  parameter int TANK_DELAY_A_LEN    = 4453,
  parameter int TANK_DELAY_B_LEN    = 3720
) (
  input  logic               clk,
  input  logic               rst,
  input  prt_pkg::cmd_t      cmd,
  output prt_pkg::sts_t      sts,
  input  logic [1:0]         mix_mode,
  input  logic [14:0]        decay_gain_one,
  input  logic [14:0]        decay_gain_two,
  input  logic [14:0]        decay_gain_three,
  input  logic signed [15:0] sample_in,
  output logic signed [15:0] sample_out,
  output logic               out_valid,
  input  logic               out_ready
);
  import prt_pkg::*;

  localparam int LENS [NUM_LINES] = '{DIFF_A_LEN, DIFF_B_LEN, DIFFUSER_C_LEN,
    DIFFUSER_D_LEN, DECAY_ALLPASS_A_LEN, DECAY_ALLPASS_B_LEN, TANK_DELAY_A_LEN,
    TANK_DELAY_B_LEN};

  logic signed [15:0] x, acc, w, t, tap, bw, dmp, fb, y;
  logic [14:0]        g;
  logic [1:0]         mode_l;

  logic signed [15:0] rdata [NUM_LINES];
  logic [NUM_LINES-1:0] busy_v;
  logic [NUM_LINES-1:0] wr_en;
  logic signed [15:0] d, wv, ap_v, tap_v, lp_v, gain_v, tap_c;
  logic               wr, out_free, adv;

  assign d      = rdata[cmd.line];
  assign ap_v   = sub_sat(acc, qmul(d, cmd.coef));
  assign tap_v  = add_sat(acc, qmul(d, cmd.coef));
  assign lp_v   = add_sat(qmul(acc, K_BW), t);
  assign gain_v = qmul(acc, g);
  assign tap_c  = (tap < -WET_LIMIT) ? -WET_LIMIT : ((tap > WET_LIMIT) ? WET_LIMIT : tap);

  always_comb begin
    wr = 1'b0;
    wv = acc;
    case (cmd.op)
      OP_AP1: begin
        wr = 1'b1;
        wv = ap_v;
      end
      OP_TAP1: begin
        wr = 1'b1;
        wv = tap_v;
      end
      OP_DELAY: begin
        wr = 1'b1;
        wv = acc;
      end
      default: begin
        wr = 1'b0;
        wv = acc;
      end
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign adv      = (cmd.op == OP_OUT) && out_free && (mode_l != MODE_BYPASS);

  for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
    assign wr_en[i] = wr && (cmd.line == line_t'(i));
    prt_line #(.DEPTH(LENS[i])) u_line (
      .clk  (clk),
      .rst  (rst),
      .rd_en(cmd.op == OP_READ),
      .wr_en(wr_en[i]),
      .adv  (adv),
      .wdata(wv),
      .rdata(rdata[i]),
      .busy (busy_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bw        <= '0;
      dmp       <= '0;
      fb        <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((cmd.op == OP_OUT) && out_free) begin
        out_valid  <= 1'b1;
        sample_out <= y;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          x      <= sample_in;
          y      <= sample_in;
          mode_l <= mix_mode;
          unique case (mix_mode)
            MODE_LIGHT: g <= decay_gain_one;
            MODE_HALF:  g <= decay_gain_two;
            default:    g <= decay_gain_three;
          endcase
        end
        OP_BW1: begin
          acc <= qmul(x, K_HALF);
          t   <= qmul(bw, K_BW_REST);
        end
        OP_BW2: begin
          acc <= lp_v;
          bw  <= lp_v;
        end
        OP_AP1:   w <= ap_v;
        OP_AP2:   acc <= add_sat(qmul(w, cmd.coef), d);
        OP_ADDFB: acc <= add_sat(acc, fb);
        OP_TAP1: begin
          w   <= tap_v;
          tap <= d;
        end
        OP_TAP2:  acc <= sub_sat(d, qmul(w, cmd.coef));
        OP_DELAY: acc <= d;
        OP_DMP1:  t <= qmul(dmp, K_BW_REST);
        OP_DMP2: begin
          acc <= lp_v;
          dmp <= lp_v;
        end
        OP_GAIN:  acc <= gain_v;
        OP_GAINFB: begin
          acc <= gain_v;
          fb  <= gain_v;
        end
        OP_MIX1: begin
          tap <= tap_c;
          t   <= qmul(x, (mode_l == MODE_LIGHT) ? K_THREEQ : K_HALF);
        end
        OP_MIX2: begin
          unique case (mode_l)
            MODE_LIGHT: y <= add_sat(t, qmul(tap, K_QUARTER));
            MODE_HALF:  y <= add_sat(t, qmul(tap, K_HALF));
            default:    y <= tap;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.busy     = |busy_v;
  assign sts.bypass   = (mix_mode == MODE_BYPASS);
  assign sts.out_free = out_free;
endmodule

/* hdl/prt_ctrl.sv */
// reverb sequencer: walks one sample through the datapath steps
// depends on prt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output prt_pkg::cmd_t cmd,
  input  prt_pkg::sts_t sts
);
  import prt_pkg::*;

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.line   = LN_DA;
    cmd.coef   = K_DIFF12;
    unique case (state)
      ST_CLEAR: begin
        if (!sts.busy) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = sts.bypass ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        cmd.op = OP_READ;
        state_next = ST_BW1;
      end
      ST_BW1: begin
        cmd.op = OP_BW1;
        state_next = ST_BW2;
      end
      ST_BW2: begin
        cmd.op = OP_BW2;
        state_next = ST_DA1;
      end
      ST_DA1: begin
        cmd.op = OP_AP1;
        state_next = ST_DA2;
      end
      ST_DA2: begin
        cmd.op = OP_AP2;
        state_next = ST_DB1;
      end
      ST_DB1: begin
        cmd.op = OP_AP1;
        cmd.line = LN_DB;
        state_next = ST_DB2;
      end
      ST_DB2: begin
        cmd.op = OP_AP2;
        cmd.line = LN_DB;
        state_next = ST_DC1;
      end
      ST_DC1: begin
        cmd.op = OP_AP1;
        cmd.line = LN_DC;
        cmd.coef = K_DIFF34;
        state_next = ST_DC2;
      end
      ST_DC2: begin
        cmd.op = OP_AP2;
        cmd.line = LN_DC;
        cmd.coef = K_DIFF34;
        state_next = ST_DD1;
      end
      ST_DD1: begin
        cmd.op = OP_AP1;
        cmd.line = LN_DD;
        cmd.coef = K_DIFF34;
        state_next = ST_DD2;
      end
      ST_DD2: begin
        cmd.op = OP_AP2;
        cmd.line = LN_DD;
        cmd.coef = K_DIFF34;
        state_next = ST_FB;
      end
      ST_FB: begin
        cmd.op = OP_ADDFB;
        state_next = ST_AA1;
      end
      ST_AA1: begin
        cmd.op = OP_TAP1;
        cmd.line = LN_AA;
        cmd.coef = K_DECAY1;
        state_next = ST_AA2;
      end
      ST_AA2: begin
        cmd.op = OP_TAP2;
        cmd.line = LN_AA;
        cmd.coef = K_DECAY1;
        state_next = ST_TA;
      end
      ST_TA: begin
        cmd.op = OP_DELAY;
        cmd.line = LN_TA;
        state_next = ST_DMP1;
      end
      ST_DMP1: begin
        cmd.op = OP_DMP1;
        state_next = ST_DMP2;
      end
      ST_DMP2: begin
        cmd.op = OP_DMP2;
        state_next = ST_G1;
      end
      ST_G1: begin
        cmd.op = OP_GAIN;
        state_next = ST_AB1;
      end
      ST_AB1: begin
        cmd.op = OP_AP1;
        cmd.line = LN_AB;
        cmd.coef = K_DECAY2;
        state_next = ST_AB2;
      end
      ST_AB2: begin
        cmd.op = OP_AP2;
        cmd.line = LN_AB;
        cmd.coef = K_DECAY2;
        state_next = ST_TB;
      end
      ST_TB: begin
        cmd.op = OP_DELAY;
        cmd.line = LN_TB;
        state_next = ST_G2;
      end
      ST_G2: begin
        cmd.op = OP_GAINFB;
        state_next = ST_MIX1;
      end
      ST_MIX1: begin
        cmd.op = OP_MIX1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.op = OP_MIX2;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.op = OP_OUT;
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_accept_start, clk, rst, (in_valid && in_ready) |=> (state == ST_READ || state == ST_OUT), "accepted word did not start processing")
  `ASSERT_CLK(a_out_hold, clk, rst, (state == ST_OUT && !sts.out_free) |=> (state == ST_OUT), "result dropped while output stalled")
  `ASSERT_CLK(a_mix_to_out, clk, rst, (state == ST_MIX2) |=> (state == ST_OUT), "mix step not followed by output")
  `ASSERT_ALWAYS(a_no_accept_in_clear, clk, (state == ST_CLEAR) |-> !in_ready, "word accepted during line clear")
endmodule

/* test/testbench.sv */
// testbench for plate_reverb_tank: random and directed samples through the reverb
// depends on prt_pkg and the plate_reverb_tank rtl; predicts each output in-house
`timescale 1ns / 1ps
module testbench;
  import prt_pkg::*;

  localparam int LEN_DA = 142;
  localparam int LEN_DB = 107;
  localparam int LEN_DC = 379;
  localparam int LEN_DD = 277;
  localparam int LEN_AA = 672;
  localparam int LEN_AB = 1800;
  localparam int LEN_TA = 4453;
  localparam int LEN_TB = 3720;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] sample_out;

  plate_reverb_tank dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
  );

  // register copies
  mode_t mode_q;
  logic [14:0] gain_q [1:3];

  // tank state
  logic signed [15:0] bw_lp, dmp_lp, fb;
  logic signed [15:0] line_da [LEN_DA];
  logic signed [15:0] line_db [LEN_DB];
  logic signed [15:0] line_dc [LEN_DC];
  logic signed [15:0] line_dd [LEN_DD];
  logic signed [15:0] line_aa [LEN_AA];
  logic signed [15:0] line_ab [LEN_AB];
  logic signed [15:0] line_ta [LEN_TA];
  logic signed [15:0] line_tb [LEN_TB];
  int p_da, p_db, p_dc, p_dd, p_aa, p_ab, p_ta, p_tb;

  logic signed [15:0] pending_words [$];
  logic signed [15:0] expected_words [$];
  int errors = 0;
  bit rx_idle_on = 1'b1;
  bit tx_idle_on = 1'b1;
  bit hold_go = 1'b0;
  bit rx_stall = 1'b0;

  function automatic int mulq(int a, int c);
    int p;
    p = a * c;
    return (p >= 0) ? p / 32768 : -((-p) / 32768);
  endfunction

  function automatic int clip16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int step_pos(int p, int n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function automatic logic signed [15:0] reverb_sample(logic signed [15:0] dry);
    int x, g, v, d, w, tap, y;
    x = int'(dry);
    if (mode_q == MODE_BYPASS) return dry;
    g = int'(gain_q[mode_q]);
    v = mulq(x, 16384);
    v = clip16(mulq(v, 32604) + mulq(int'(bw_lp), 164));
    bw_lp = 16'(v);
    d = int'(line_da[p_da]); w = clip16(v - mulq(d, 24576)); line_da[p_da] = 16'(w);
    p_da = step_pos(p_da, LEN_DA); v = clip16(mulq(w, 24576) + d);
    d = int'(line_db[p_db]); w = clip16(v - mulq(d, 24576)); line_db[p_db] = 16'(w);
    p_db = step_pos(p_db, LEN_DB); v = clip16(mulq(w, 24576) + d);
    d = int'(line_dc[p_dc]); w = clip16(v - mulq(d, 20480)); line_dc[p_dc] = 16'(w);
    p_dc = step_pos(p_dc, LEN_DC); v = clip16(mulq(w, 20480) + d);
    d = int'(line_dd[p_dd]); w = clip16(v - mulq(d, 20480)); line_dd[p_dd] = 16'(w);
    p_dd = step_pos(p_dd, LEN_DD); v = clip16(mulq(w, 20480) + d);
    v = clip16(v + int'(fb));
    d = int'(line_aa[p_aa]); w = clip16(v + mulq(d, 16384)); tap = d;
    line_aa[p_aa] = 16'(w);
    p_aa = step_pos(p_aa, LEN_AA); v = clip16(d - mulq(w, 16384));
    d = int'(line_ta[p_ta]); line_ta[p_ta] = 16'(v); p_ta = step_pos(p_ta, LEN_TA); v = d;
    v = clip16(mulq(v, 32604) + mulq(int'(dmp_lp), 164));
    dmp_lp = 16'(v);
    v = mulq(v, g);
    d = int'(line_ab[p_ab]); w = clip16(v - mulq(d, 13107)); line_ab[p_ab] = 16'(w);
    p_ab = step_pos(p_ab, LEN_AB); v = clip16(mulq(w, 13107) + d);
    d = int'(line_tb[p_tb]); line_tb[p_tb] = 16'(v); p_tb = step_pos(p_tb, LEN_TB); v = d;
    fb = 16'(mulq(v, g));
    if (tap < -16384) tap = -16384;
    if (tap > 16384) tap = 16384;
    if (mode_q == MODE_LIGHT) y = clip16(mulq(x, 24576) + mulq(tap, 8192));
    else if (mode_q == MODE_HALF) y = clip16(mulq(x, 16384) + mulq(tap, 16384));
    else y = tap;
    return y[15:0];
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  // long receiver stall
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (400) @(posedge clk);
    rx_stall <= 1'b0;
  end

  // sender
  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_words.push_back(reverb_sample(sample_in));
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (tx_idle_on && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          sample_in <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int rx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %0d", $time, sample_out);
          errors++;
        end else begin
          logic signed [15:0] want;
          want = expected_words.pop_front();
          if (want !== sample_out) begin
            $display("%0t mismatch: expected %0d, actual %0d", $time, want, sample_out);
            errors++;
          end
        end
      end
      if (rx_stall) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE: mode_q = mode_t'(val[1:0]);
      REG_GAIN1: gain_q[1] = val[14:0];
      REG_GAIN2: gain_q[2] = val[14:0];
      default: gain_q[3] = val[14:0];
    endcase
  endtask

  task automatic drain;
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] extremes [8];
    extremes = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                 16'sh5555, 16'shaaaa, 16'sh4000};
    mode_q = MODE_BYPASS;
    gain_q[1] = GAIN_ONE_RST;
    gain_q[2] = GAIN_TWO_RST;
    gain_q[3] = GAIN_THREE_RST;
    bw_lp = 0; dmp_lp = 0; fb = 0;
    foreach (line_da[i]) line_da[i] = 0;
    foreach (line_db[i]) line_db[i] = 0;
    foreach (line_dc[i]) line_dc[i] = 0;
    foreach (line_dd[i]) line_dd[i] = 0;
    foreach (line_aa[i]) line_aa[i] = 0;
    foreach (line_ab[i]) line_ab[i] = 0;
    foreach (line_ta[i]) line_ta[i] = 0;
    foreach (line_tb[i]) line_tb[i] = 0;
    p_da = 0; p_db = 0; p_dc = 0; p_dd = 0; p_aa = 0; p_ab = 0; p_ta = 0; p_tb = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: bypass, then each mode with extremes, extra register bits
    foreach (extremes[i]) pending_words.push_back(extremes[i]);
    drain();
    for (int m = 1; m <= 3; m++) begin
      reg_write(REG_MODE, 32'hffff_fffc | m);
      foreach (extremes[i]) pending_words.push_back(extremes[i]);
      drain();
    end
    reg_write(REG_GAIN1, 32'hffff_ffff);
    reg_write(REG_GAIN2, 32'h0000_0000);
    reg_write(REG_GAIN3, 32'h0001_7fff);

    // random phases with varying settings
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_MODE, $urandom_range(0, 3));
      reg_write(REG_GAIN1, ph[0] ? 32'h7fff : $urandom);
      reg_write(REG_GAIN2, ph[1] ? 32'h0 : $urandom);
      reg_write(REG_GAIN3, ph[2] ? 32'h7fff : $urandom_range(0, 32767));
      if (ph >= 8) begin
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
      end
      if (ph == 4) begin
        hold_go = 1'b1;
      end
      for (int k = 0; k < 70; k++) pending_words.push_back(rand_sample());
      // sender pauses until every word has come back
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
